### hw/rtl/kfd_pkg.sv
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared types and constants for the keypad frame deframer.
// ----------------------------------------------------------------------------
package kfd_pkg;

  // Default frame geometry.
  localparam int unsigned IV_BYTES_DEF    = 16;
  localparam int unsigned MAX_PAYLOAD_DEF = 255;

  // Position counter width, header length in bytes and payload compare width.
  localparam int unsigned POS_W      = 9;
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned MAXPAY_W   = 13;

  localparam logic [7:0] CKSUM_SEED = 8'h7E;
  localparam logic [7:0] STOP_MARK  = 8'h81;

  typedef enum logic [3:0] {
    KIND_SIZE     = 4'd0,
    KIND_ID       = 4'd1,
    KIND_ADDRESS  = 4'd2,
    KIND_FUNCTION = 4'd3,
    KIND_IV       = 4'd4,
    KIND_PAYLOAD  = 4'd5,
    KIND_CHECKSUM = 4'd6,
    KIND_STOP     = 4'd7,
    KIND_STRAY    = 4'd8
  } field_kind_t;

  typedef enum logic [2:0] {
    STAT_PENDING  = 3'd0,
    STAT_OK       = 3'd1,
    STAT_BAD_STOP = 3'd2,
    STAT_BAD_CKS  = 3'd3,
    STAT_OUTSIDE  = 3'd4
  } frame_status_t;

endpackage

### hw/rtl/keypad_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// keypad_frame_deframer_top
// Tags each received frame byte with its field and index, and checks the
// stop byte and XOR checksum at the end of the frame.
// ----------------------------------------------------------------------------
// The deframer takes one byte per clock cycle while out_ready stays high and
// gives exactly one result per byte. An accepted byte is held in the input
// register, classified against the frame state from there and registered into
// the result register that drives the output. While a result waits, the input
// register takes one more request and then in_ready drops until out_ready returns.
// A byte with in_frame_start high always opens a new frame and samples
// in_payload_length. Outside a frame, bytes come back as stray bytes.
module keypad_frame_deframer_top #(
  parameter int unsigned IV_BYTES    = kfd_pkg::IV_BYTES_DEF,
  parameter int unsigned MAX_PAYLOAD = kfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  input  logic [7:0] in_payload_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_field_kind,
  output logic [7:0] out_field_index,
  output logic [7:0] out_field_byte,
  output logic       out_frame_end,
  output logic [2:0] out_frame_status
);

  localparam int unsigned PW = kfd_pkg::POS_W;
  localparam logic [PW-1:0] HdrEnd = PW'(kfd_pkg::HDR_BYTES);
  localparam logic [PW-1:0] IvEnd  = PW'(kfd_pkg::HDR_BYTES + IV_BYTES);
  localparam logic [kfd_pkg::MAXPAY_W-1:0] MaxPay = kfd_pkg::MAXPAY_W'(MAX_PAYLOAD);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic [7:0] s1_len_r;

  // Frame state.
  logic          in_frame_r, in_frame_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    cksum_r, cksum_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    rx_cksum_r, rx_cksum_nxt;

  // Result register.
  logic                   out_valid_r;
  kfd_pkg::field_kind_t   kind_r, kind_nxt;
  logic [7:0]             index_r, index_nxt;
  logic [7:0]             byte_r;
  logic                   end_r, end_nxt;
  kfd_pkg::frame_status_t status_r, status_nxt;

  logic          out_free;
  logic          s1_move;
  logic          eff_in_frame;
  logic [PW-1:0] eff_pos;
  logic [7:0]    eff_cksum;
  logic [7:0]    eff_len;
  logic [PW-1:0] pay_end;

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
      s1_len_r   <= in_payload_length;
    end
  end

  // A frame start resets the frame state before the byte is classified.
  always_comb begin
    if (s1_start_r) begin
      eff_in_frame = 1'b1;
      eff_pos      = '0;
      eff_cksum    = kfd_pkg::CKSUM_SEED;
      if ({{(kfd_pkg::MAXPAY_W-8){1'b0}}, s1_len_r} > MaxPay) begin
        eff_len = MaxPay[7:0];
      end else begin
        eff_len = s1_len_r;
      end
    end else begin
      eff_in_frame = in_frame_r;
      eff_pos      = pos_r;
      eff_cksum    = cksum_r;
      eff_len      = len_r;
    end
  end

  assign pay_end = IvEnd + {{(PW-8){1'b0}}, eff_len};

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    cksum_nxt    = cksum_r;
    len_nxt      = len_r;
    rx_cksum_nxt = rx_cksum_r;
    kind_nxt     = kfd_pkg::KIND_STRAY;
    index_nxt    = '0;
    end_nxt      = 1'b0;
    status_nxt   = kfd_pkg::STAT_OUTSIDE;
    if (eff_in_frame) begin
      in_frame_nxt = 1'b1;
      len_nxt      = eff_len;
      cksum_nxt    = eff_cksum;
      pos_nxt      = eff_pos + PW'(1);
      status_nxt   = kfd_pkg::STAT_PENDING;
      priority if (eff_pos < HdrEnd) begin
        cksum_nxt = eff_cksum ^ s1_byte_r;
        unique case (eff_pos[1:0])
          2'd0:    kind_nxt = kfd_pkg::KIND_SIZE;
          2'd1:    kind_nxt = kfd_pkg::KIND_ID;
          2'd2:    kind_nxt = kfd_pkg::KIND_ADDRESS;
          default: kind_nxt = kfd_pkg::KIND_FUNCTION;
        endcase
      end else if (eff_pos < IvEnd) begin
        cksum_nxt = eff_cksum ^ s1_byte_r;
        kind_nxt  = kfd_pkg::KIND_IV;
        index_nxt = 8'(eff_pos - HdrEnd);
      end else if (eff_pos < pay_end) begin
        cksum_nxt = eff_cksum ^ s1_byte_r;
        kind_nxt  = kfd_pkg::KIND_PAYLOAD;
        index_nxt = 8'(eff_pos - IvEnd);
      end else if (eff_pos == pay_end) begin
        kind_nxt     = kfd_pkg::KIND_CHECKSUM;
        rx_cksum_nxt = s1_byte_r;
      end else begin
        kind_nxt     = kfd_pkg::KIND_STOP;
        end_nxt      = 1'b1;
        in_frame_nxt = 1'b0;
        // The stop byte is checked before the checksum.
        if (s1_byte_r != kfd_pkg::STOP_MARK) begin
          status_nxt = kfd_pkg::STAT_BAD_STOP;
        end else if (~eff_cksum != rx_cksum_r) begin
          status_nxt = kfd_pkg::STAT_BAD_CKS;
        end else begin
          status_nxt = kfd_pkg::STAT_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      cksum_r    <= kfd_pkg::CKSUM_SEED;
      len_r      <= '0;
      rx_cksum_r <= '0;
    end else if (s1_move) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      cksum_r    <= cksum_nxt;
      len_r      <= len_nxt;
      rx_cksum_r <= rx_cksum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      kind_r   <= kind_nxt;
      index_r  <= index_nxt;
      byte_r   <= s1_byte_r;
      end_r    <= end_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_field_kind   = kind_r;
  assign out_field_index  = index_r;
  assign out_field_byte   = byte_r;
  assign out_frame_end    = end_r;
  assign out_frame_status = status_r;

endmodule

### hw/rtl/kfd_checker.sv
// ----------------------------------------------------------------------------
// kfd_checker
// Port-level checks for the keypad frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module kfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_field_kind,
  input logic [7:0] out_field_index,
  input logic [7:0] out_field_byte,
  input logic       out_frame_end,
  input logic [2:0] out_frame_status
);

  // With no result waiting, a request is always taken.
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !out_valid) |-> in_ready)
    else $error("request refused while no result waits");

  // The end flag marks exactly the stop byte.
  a_end_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end == (out_field_kind == kfd_pkg::KIND_STOP)))
    else $error("frame_end does not match the stop field");

  // A stop result always carries a final verdict.
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |->
      (out_frame_status == kfd_pkg::STAT_OK ||
       out_frame_status == kfd_pkg::STAT_BAD_STOP ||
       out_frame_status == kfd_pkg::STAT_BAD_CKS))
    else $error("stop byte without a verdict");

  // Stray bytes and the outside status go together, with index zero.
  a_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_status == kfd_pkg::STAT_OUTSIDE) ==
                   (out_field_kind == kfd_pkg::KIND_STRAY)) &&
                  (out_field_kind != kfd_pkg::KIND_STRAY || out_field_index == 8'd0))
    else $error("stray byte tagged inconsistently");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_field_byte) &&
                                   $stable(out_field_kind)))
    else $error("result changed while stalled");

endmodule

bind keypad_frame_deframer_top kfd_checker u_kfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_field_kind   (out_field_kind),
  .out_field_index  (out_field_index),
  .out_field_byte   (out_field_byte),
  .out_frame_end    (out_frame_end),
  .out_frame_status (out_frame_status)
);
